FILE: hw/rtl/ssds_pkg.sv
// ----------------------------------------------------------------------------
// ssds_pkg: shared types and constants of the seven-segment scanner
// command codes, queue entry type, back-end states and the digit pattern table
// ----------------------------------------------------------------------------
package ssds_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int CMD_W           = 2;
    localparam int VALUE_W         = 32;
    localparam int SEL_W           = 3;
    localparam int SEG_W           = 8;
    localparam int FLUSH_MAX       = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PROD_W          = 2 * VALUE_W;
    localparam int RECIP_SHIFT     = 35;

    // command codes on the request port
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // ceil(2^35 / 10): exact divide by ten for any 32-bit value
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_ZERO  = 8'h3F;

    typedef enum logic [1:0] {
        OP_SET,
        OP_TICK,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_FLUSH
    } t_state;

    // decimal digit to segment pattern, bit0 a .. bit6 g
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

FILE: hw/rtl/ssds_front.sv
// ----------------------------------------------------------------------------
// ssds_front: request decode
// takes requests while the queue has room, drops unknown commands
// ----------------------------------------------------------------------------
module ssds_front (
    input  logic                          i_start,
    input  logic [ssds_pkg::CMD_W-1:0]    i_command,
    input  logic [ssds_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_full,
    output logic                          o_busy,
    output logic                          o_push,
    output ssds_pkg::t_item               o_item
);

    logic w_accept;

    assign o_busy   = i_full;
    assign w_accept = i_start && !i_full;

    always_comb begin
        o_item.value = i_value;
        o_item.op    = ssds_pkg::OP_SET;
        o_push       = 1'b0;
        unique case (i_command)
            ssds_pkg::CMD_SET: begin
                o_item.op = ssds_pkg::OP_SET;
                o_push    = w_accept;
            end
            ssds_pkg::CMD_TICK: begin
                o_item.op = ssds_pkg::OP_TICK;
                o_push    = w_accept;
            end
            ssds_pkg::CMD_FLUSH: begin
                o_item.op = ssds_pkg::OP_FLUSH;
                o_push    = w_accept;
            end
            default: begin
                // unknown code: taken, then ignored
                o_push = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ssds_queue.sv
// ----------------------------------------------------------------------------
// ssds_queue: short request queue
// decouples request decode from the digit engine
// ----------------------------------------------------------------------------
module ssds_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ssds_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ssds_pkg::t_item o_item
);

    localparam int PTR_W = (ssds_pkg::QUEUE_DEPTH > 1) ? $clog2(ssds_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ssds_pkg::QUEUE_DEPTH + 1);

    ssds_pkg::t_item r_slot [ssds_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(ssds_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(ssds_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(ssds_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/ssds_back.sv
// ----------------------------------------------------------------------------
// ssds_back: digit engine
// converts numbers to patterns one digit at a time, emits scan and flush results
// ----------------------------------------------------------------------------
module ssds_back #(
    parameter int DIGIT_COUNT = ssds_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  ssds_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [ssds_pkg::SEL_W-1:0]   o_digit_select,
    output logic [ssds_pkg::SEG_W-1:0]   o_segments,
    output logic                         o_last_of_run
);

    localparam int IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int FLUSH_N = (DIGIT_COUNT < ssds_pkg::FLUSH_MAX) ? DIGIT_COUNT
                                                                 : ssds_pkg::FLUSH_MAX;
    localparam int QUOT_W  = ssds_pkg::PROD_W - ssds_pkg::RECIP_SHIFT;

    ssds_pkg::t_state r_state, n_state;

    logic [ssds_pkg::SEG_W-1:0]   r_store [DIGIT_COUNT];
    logic [ssds_pkg::SEG_W-1:0]   n_store [DIGIT_COUNT];
    logic [ssds_pkg::VALUE_W-1:0] r_num, n_num;
    logic [ssds_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [ssds_pkg::SEL_W-1:0]   r_scan, n_scan;
    logic                         r_strobe, n_strobe;
    logic [ssds_pkg::SEL_W-1:0]   r_sel, n_sel;
    logic [ssds_pkg::SEG_W-1:0]   r_seg, n_seg;
    logic                         r_last, n_last;

    logic [QUOT_W-1:0]            w_quot;
    logic [ssds_pkg::VALUE_W-1:0] w_quot_ext;
    logic [ssds_pkg::VALUE_W-1:0] w_q10;
    logic [ssds_pkg::VALUE_W-1:0] w_rem;
    logic [IDX_W+2:0]             w_scan_ext;
    logic [IDX_W+2:0]             w_idx_ext;
    logic [IDX_W-1:0]             w_rd_addr;
    logic [ssds_pkg::SEG_W-1:0]   w_rd_seg;
    logic [4:0]                   w_scan_inc;
    logic [ssds_pkg::SEL_W-1:0]   w_scan_next;
    logic                         w_flush_end;
    logic                         w_dig_end;

    // quotient and remainder of the divide-by-ten step
    assign w_quot     = r_prod[ssds_pkg::PROD_W-1:ssds_pkg::RECIP_SHIFT];
    assign w_quot_ext = ssds_pkg::VALUE_W'(w_quot);
    assign w_q10      = (w_quot_ext << 3) + (w_quot_ext << 1);
    assign w_rem      = r_num - w_q10;
    assign w_dig_end  = (w_quot == '0) || (r_idx == '0);

    // single read port of the digit store
    assign w_scan_ext = {{IDX_W{1'b0}}, r_scan};
    assign w_idx_ext  = {3'b000, r_idx};
    assign w_rd_addr  = (r_state == ssds_pkg::ST_FLUSH) ? r_idx : w_scan_ext[IDX_W-1:0];
    assign w_rd_seg   = r_store[w_rd_addr];

    assign w_scan_inc  = {2'b00, r_scan} + 5'd1;
    assign w_scan_next = (w_scan_inc == 5'(DIGIT_COUNT)) ? '0 : w_scan_inc[2:0];
    assign w_flush_end = (r_idx == IDX_W'(FLUSH_N - 1));

    assign o_pop = (r_state == ssds_pkg::ST_IDLE) && i_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssds_pkg::ST_IDLE: begin
                if (i_valid && i_item.op == ssds_pkg::OP_SET && i_item.value != '0) begin
                    n_state = ssds_pkg::ST_MUL;
                end else if (i_valid && i_item.op == ssds_pkg::OP_FLUSH) begin
                    n_state = ssds_pkg::ST_FLUSH;
                end
            end
            ssds_pkg::ST_MUL: begin
                n_state = ssds_pkg::ST_DIG;
            end
            ssds_pkg::ST_DIG: begin
                n_state = w_dig_end ? ssds_pkg::ST_IDLE : ssds_pkg::ST_MUL;
            end
            ssds_pkg::ST_FLUSH: begin
                if (w_flush_end) begin
                    n_state = ssds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssds_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_store  = r_store;
        n_num    = r_num;
        n_prod   = r_prod;
        n_idx    = r_idx;
        n_scan   = r_scan;
        n_strobe = 1'b0;
        n_sel    = r_sel;
        n_seg    = r_seg;
        n_last   = 1'b0;
        unique case (r_state)
            ssds_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op)
                        ssds_pkg::OP_SET: begin
                            for (int i = 0; i < DIGIT_COUNT; i++) begin
                                n_store[i] = ssds_pkg::SEG_BLANK;
                            end
                            if (i_item.value == '0) begin
                                n_store[DIGIT_COUNT-1] = ssds_pkg::SEG_ZERO;
                            end
                            n_num = i_item.value;
                            n_idx = IDX_W'(DIGIT_COUNT - 1);
                        end
                        ssds_pkg::OP_TICK: begin
                            n_strobe = 1'b1;
                            n_sel    = r_scan;
                            n_seg    = w_rd_seg;
                            n_last   = 1'b1;
                            n_scan   = w_scan_next;
                        end
                        ssds_pkg::OP_FLUSH: begin
                            n_idx = '0;
                        end
                        default: begin
                            n_idx = r_idx;
                        end
                    endcase
                end
            end
            ssds_pkg::ST_MUL: begin
                n_prod = {{ssds_pkg::VALUE_W{1'b0}}, r_num}
                       * {{ssds_pkg::VALUE_W{1'b0}}, ssds_pkg::RECIP_10};
            end
            ssds_pkg::ST_DIG: begin
                n_store[r_idx] = ssds_pkg::seg_of(w_rem[3:0]);
                n_num          = w_quot_ext;
                if (!w_dig_end) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ssds_pkg::ST_FLUSH: begin
                n_strobe = 1'b1;
                n_sel    = w_idx_ext[2:0];
                n_seg    = w_rd_seg;
                n_last   = w_flush_end;
                if (!w_flush_end) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssds_pkg::ST_IDLE;
            r_scan   <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_store[i] <= ssds_pkg::SEG_BLANK;
            end
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            r_store  <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_prod <= n_prod;
        r_idx  <= n_idx;
        r_sel  <= n_sel;
        r_seg  <= n_seg;
    end

    assign o_strobe       = r_strobe;
    assign o_digit_select = r_sel;
    assign o_segments     = r_seg;
    assign o_last_of_run  = r_last;

endmodule

FILE: hw/rtl/seven_segment_decimal_scanner.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_scanner: eight-digit multiplexed display driver
// set, scan tick and flush requests drive a common-cathode seven-segment display
// ----------------------------------------------------------------------------
//
//   channel   | signals                                     | handshake
//   ----------+---------------------------------------------+---------------------------
//   request   | i_command, i_value                          | start high, busy low
//   result    | o_digit_select, o_segments, o_last_of_run   | o_strobe, one cycle each
//
// a request is registered in the queue before the digit engine takes it
// tick: one result, passed through the queue and then the result register
// flush: min(DIGIT_COUNT, 8) results on consecutive cycles
// set: taken from the queue, then per decimal digit a reciprocal multiply step
//   and a remainder and store write step, for at most DIGIT_COUNT digits;
//   a set of zero writes its pattern as it is taken from the queue
// busy is high while the two-entry queue is full; results cannot be held off
// reset is synchronous, active low, and blanks the digit store and scan position
//
module seven_segment_decimal_scanner #(
    parameter int DIGIT_COUNT = ssds_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ssds_pkg::CMD_W-1:0]   i_command,
    input  logic [ssds_pkg::VALUE_W-1:0] i_value,
    output logic                         o_strobe,
    output logic [ssds_pkg::SEL_W-1:0]   o_digit_select,
    output logic [ssds_pkg::SEG_W-1:0]   o_segments,
    output logic                         o_last_of_run
);

    // decode to queue
    logic            w_push;
    ssds_pkg::t_item w_push_item;
    logic            w_full;

    // queue to digit engine
    logic            w_head_valid;
    ssds_pkg::t_item w_head_item;
    logic            w_pop;

    // front: accepts a request whenever the queue has room
    ssds_front u_front (
        .i_start   (start),
        .i_command (i_command),
        .i_value   (i_value),
        .i_full    (w_full),
        .o_busy    (busy),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    // queue: lets requests pile up while a set is still converting
    ssds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_item  (w_head_item)
    );

    // back: digit store, divide-by-ten loop and result register
    ssds_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_head_valid),
        .i_item         (w_head_item),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_last_of_run  (o_last_of_run)
    );

    // the run-end flag never stands without a result
    a_last_needs_strobe : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |-> o_strobe
    ) else $error("last_of_run without strobe");

    // a run that has not ended continues next cycle at the next position
    a_flush_in_order : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_of_run) |=>
            (o_strobe && o_digit_select == 3'($past(o_digit_select) + 3'd1))
    ) else $error("flush results out of order or broken up");

    // busy only while the queue holds requests
    a_busy_means_queued : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_head_valid
    ) else $error("busy with an empty queue");

endmodule

FILE: tb/tb_seven_segment_decimal_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_decimal_scanner: self-checking bench of the display scanner
// a clocked driver plays set, scan tick, flush and unused-code requests from a
// queue filled up front; a shadow copy of the digit store and scan position
// predicts every strobed digit, and a clocked monitor compares each one
// ----------------------------------------------------------------------------
module tb_seven_segment_decimal_scanner;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 96;
    localparam int DRAIN_CYCLES  = 40;      // covers the longest set plus queue
    localparam int CYCLE_LIMIT   = 200000;
    localparam int FLUSH_N       = (ssds_pkg::DIGIT_COUNT_DEF < ssds_pkg::FLUSH_MAX)
                                   ? ssds_pkg::DIGIT_COUNT_DEF : ssds_pkg::FLUSH_MAX;

    // the one command code the block ignores
    localparam logic [ssds_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [ssds_pkg::CMD_W-1:0]   cmd;
        logic [ssds_pkg::VALUE_W-1:0] value;
        int                           gap_pct;    // chance of idling before this request
    } t_request;

    typedef struct {
        logic [ssds_pkg::SEL_W-1:0] sel;
        logic [ssds_pkg::SEG_W-1:0] seg;
        logic                       last;
    } t_digit_out;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           start      = 1'b0;
    logic [ssds_pkg::CMD_W-1:0]     i_command  = ssds_pkg::CMD_SET;
    logic [ssds_pkg::VALUE_W-1:0]   i_value    = '0;
    logic                           busy;
    logic                           o_strobe;
    logic [ssds_pkg::SEL_W-1:0]     o_digit_select;
    logic [ssds_pkg::SEG_W-1:0]     o_segments;
    logic                           o_last_of_run;

    // decimal digit to common-cathode pattern, segment a in bit 0
    logic [ssds_pkg::SEG_W-1:0] digit_pattern [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // shadow of the display state
    logic [ssds_pkg::SEG_W-1:0] shown_digits [ssds_pkg::DIGIT_COUNT_DEF] =
        '{default: ssds_pkg::SEG_BLANK};
    logic [ssds_pkg::SEL_W-1:0] scan_pos = '0;

    t_request   pending_requests [$];
    t_digit_out expected_digits  [$];
    int         error_count = 0;
    int         cycle_count = 0;

    seven_segment_decimal_scanner u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_last_of_run  (o_last_of_run)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // update the shadow display for one taken request and queue its digits
    task automatic predict_display(input logic [ssds_pkg::CMD_W-1:0] cmd,
                                   input logic [ssds_pkg::VALUE_W-1:0] value);
        logic [ssds_pkg::VALUE_W-1:0] rest;
        int                           pos;
        t_digit_out                   res;
        case (cmd)
            ssds_pkg::CMD_SET: begin
                shown_digits = '{default: ssds_pkg::SEG_BLANK};
                rest = value;
                if (rest == 0) begin
                    // zero still lights the rightmost digit
                    shown_digits[ssds_pkg::DIGIT_COUNT_DEF-1] = ssds_pkg::SEG_ZERO;
                end else begin
                    // fill from the right; digits above the eighth fall away
                    pos = ssds_pkg::DIGIT_COUNT_DEF;
                    while (rest != 0 && pos > 0) begin
                        pos--;
                        shown_digits[pos] = digit_pattern[rest % 10];
                        rest = rest / 10;
                    end
                end
            end
            ssds_pkg::CMD_TICK: begin
                res.sel  = scan_pos;
                res.seg  = shown_digits[scan_pos];
                res.last = 1'b1;
                expected_digits.push_back(res);
                if (scan_pos == ssds_pkg::SEL_W'(ssds_pkg::DIGIT_COUNT_DEF - 1)) begin
                    scan_pos = '0;
                end else begin
                    scan_pos = scan_pos + 1'b1;
                end
            end
            ssds_pkg::CMD_FLUSH: begin
                // leftmost first; scan position is left alone
                for (int k = 0; k < FLUSH_N; k++) begin
                    res.sel  = ssds_pkg::SEL_W'(k);
                    res.seg  = shown_digits[k];
                    res.last = (k == FLUSH_N - 1);
                    expected_digits.push_back(res);
                end
            end
            default: begin
                // unused code: no digit, no state change
            end
        endcase
    endtask

    task automatic add_request(input logic [ssds_pkg::CMD_W-1:0] cmd,
                               input logic [ssds_pkg::VALUE_W-1:0] value,
                               input int gap_pct);
        t_request req;
        req.cmd     = cmd;
        req.value   = value;
        req.gap_pct = gap_pct;
        pending_requests.push_back(req);
    endtask

    // driver: a request is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_display(i_command, i_value);
                void'(pending_requests.pop_front());
            end
            if (start && busy) begin
                // held off: keep the same request on the port
            end else if (pending_requests.size() != 0 &&
                         $urandom_range(0, 99) >= pending_requests[0].gap_pct) begin
                start     <= 1'b1;
                i_command <= pending_requests[0].cmd;
                i_value   <= pending_requests[0].value;
            end else begin
                // idle cycle, junk on the data lines
                start     <= 1'b0;
                i_command <= ssds_pkg::CMD_W'($urandom);
                i_value   <= $urandom;
            end
        end
    end

    // monitor: every strobe is one digit, compared against the oldest prediction
    always @(posedge i_clk) begin
        t_digit_out want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                $error("o_strobe unknown after reset");
                error_count++;
            end else if (o_strobe) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit: digit_select %0d segments %h last_of_run %b",
                           o_digit_select, o_segments, o_last_of_run);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (o_digit_select !== want.sel) begin
                        $error("digit_select: expected %0d, got %0d", want.sel,
                               o_digit_select);
                        error_count++;
                    end
                    if (o_segments !== want.seg) begin
                        $error("segments: expected %h, got %h", want.seg, o_segments);
                        error_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last,
                               o_last_of_run);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int                           pick;
        int                           ndig;
        int                           gap;
        logic [ssds_pkg::CMD_W-1:0]   cmd;
        logic [ssds_pkg::VALUE_W-1:0] raw;
        longint unsigned              scale;

        // directed: blank store after reset, zero, overlong numbers, full wrap
        add_request(ssds_pkg::CMD_FLUSH, 32'h0, 29);
        add_request(ssds_pkg::CMD_TICK,  32'h0, 29);
        add_request(ssds_pkg::CMD_SET,   32'd0, 29);
        add_request(ssds_pkg::CMD_FLUSH, 32'h0, 29);
        add_request(ssds_pkg::CMD_SET,   32'hFFFF_FFFF, 29);   // ten digits, top two dropped
        add_request(ssds_pkg::CMD_FLUSH, 32'h0, 29);
        add_request(ssds_pkg::CMD_SET,   32'd100000000, 29);   // lowest eight all zero
        add_request(ssds_pkg::CMD_FLUSH, 32'h0, 29);
        add_request(ssds_pkg::CMD_SET,   32'd99999999, 29);
        add_request(ssds_pkg::CMD_FLUSH, 32'h0, 29);
        add_request(ssds_pkg::CMD_SET,   32'd12345678, 29);
        for (int k = 0; k < ssds_pkg::DIGIT_COUNT_DEF; k++) begin
            add_request(ssds_pkg::CMD_TICK, $urandom, 29);       // one full scan lap
        end
        add_request(CMD_NONE,            32'hFFFF_FFFF, 29);
        add_request(ssds_pkg::CMD_SET,   32'd7, 29);
        add_request(CMD_NONE,            32'h0, 29);
        add_request(ssds_pkg::CMD_TICK,  32'h0, 29);
        add_request(ssds_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 29);

        // random: sender gap 29 percent, then 67, then back to back
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gap  = (i < RANDOM_ITEMS / 3) ? 29 : (i < 2 * RANDOM_ITEMS / 3) ? 67 : 0;
            pick = $urandom_range(0, 99);
            cmd  = (pick < 30) ? ssds_pkg::CMD_SET : (pick < 70) ? ssds_pkg::CMD_TICK :
                   (pick < 94) ? ssds_pkg::CMD_FLUSH : CMD_NONE;
            raw  = $urandom;
            if (cmd == ssds_pkg::CMD_SET) begin
                // spread the digit count from zero up past eight
                ndig  = $urandom_range(0, 10);
                scale = 1;
                repeat (ndig) scale = scale * 10;
                if (ndig < 10) begin
                    raw = ssds_pkg::VALUE_W'(longint'(raw) % scale);
                end
            end
            add_request(cmd, raw, gap);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all requests taken and every predicted digit seen
        while (pending_requests.size() != 0 || start || expected_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
